>>> rtl/multi_queue_urgent_front_insert_assert.svh
// Assertion macros for the queue bank.
`ifndef MULTI_QUEUE_URGENT_FRONT_INSERT_ASSERT_SVH
`define MULTI_QUEUE_URGENT_FRONT_INSERT_ASSERT_SVH

// Same-cycle implication.
`define MQUFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MQUFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mqufi_pkg.sv
`default_nettype none

package mqufi_pkg;

  localparam int QIDX_W      = 5;
  localparam int TAG_FIELD_W = 16;
  localparam int STATUS_W    = 3;
  localparam int LEN_FIELD_W = 3;

  typedef enum logic {
    ACT_ADD    = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_REMOVED = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_INVALID = 3'd4
  } status_t;

  typedef struct packed {
    action_t                  action;
    logic [QIDX_W-1:0]        queue_index;
    logic                     urgent;
    logic [TAG_FIELD_W-1:0]   entry_tag;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic [TAG_FIELD_W-1:0]   popped_tag;
    logic [LEN_FIELD_W-1:0]   queue_length;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/multi_queue_urgent_front_insert.sv
// Bank of NUM_QUEUES bounded queues of QUEUE_DEPTH tags each.
// req channel (req_valid/req_ready/req): one word names a queue and either
//   adds a tag (urgent adds go to the head, regular ones to the tail) or
//   removes the head tag.
// rsp channel (rsp_valid/rsp_ready/rsp): exactly one word per request with
//   status, popped tag and the queue length after the operation.
// Each queue is a ring in one shared single-port entry memory, with a head
//   pointer and a length per queue in flops. One request runs through a
//   three-step sequencer: accept, execute (pointer update and one memory
//   access at a computed address), emit into the rsp register.
// req_ready is low while busy: a new request waits until the previous one has
//   left the sequencer.
// If rsp_ready is low, the sequencer holds its result until the rsp register
//   frees up; the next request is still accepted once that result is loaded.
// Reset (rst, synchronous) empties every queue at once; no clearing pass.
`default_nettype none

module multi_queue_urgent_front_insert
  import mqufi_pkg::*;
#(
  parameter int NUM_QUEUES  = 20,
  parameter int QUEUE_DEPTH = 5,
  parameter int TAG_WIDTH   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW  = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW  = (TAG_WIDTH < TAG_FIELD_W) ? TAG_WIDTH : TAG_FIELD_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

  state_t          state;
  req_t            req_q;
  logic [LW-1:0]   lens  [NUM_QUEUES];
  logic [PW-1:0]   heads [NUM_QUEUES];
  status_t         res_status;
  logic [LW-1:0]   res_len;
  logic            res_pop;

  logic [SW-1:0]   mem [MEM_DEPTH];
  logic [SW-1:0]   rd_data;

  logic [QW-1:0]   qi;
  logic            q_ok;
  logic [LW-1:0]   len_cur;
  logic [PW-1:0]   head_cur;
  logic [PW-1:0]   head_dec;
  logic [PW-1:0]   head_inc;
  logic [LW:0]     tail_sum;
  logic [PW-1:0]   tail;
  logic            full;
  logic            is_add;
  logic [PW-1:0]   slot;
  logic [AW-1:0]   mem_addr;
  logic            exec;
  logic            mem_we;
  logic            rsp_load;

  assign req_ready = (state == S_IDLE);
  assign exec      = (state == S_EXEC);
  assign rsp_load  = (state == S_EMIT) && (!rsp_valid || rsp_ready);

  assign qi       = req_q.queue_index[QW-1:0];
  assign q_ok     = (QIDX_W+1)'(req_q.queue_index) < (QIDX_W+1)'(NUM_QUEUES);
  assign len_cur  = lens[qi];
  assign head_cur = heads[qi];
  assign is_add   = (req_q.action == ACT_ADD);
  assign full     = (len_cur == LW'(QUEUE_DEPTH));

  assign head_dec = (head_cur == '0) ? PW'(QUEUE_DEPTH - 1) : head_cur - 1'b1;
  assign head_inc = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + 1'b1;
  assign tail_sum = (LW+1)'(head_cur) + (LW+1)'(len_cur);
  assign tail     = (tail_sum >= (LW+1)'(QUEUE_DEPTH))
                    ? PW'(tail_sum - (LW+1)'(QUEUE_DEPTH)) : PW'(tail_sum);

  always_comb begin
    if (!is_add) begin
      slot = head_cur;
    end else if (req_q.urgent) begin
      slot = head_dec;
    end else begin
      slot = tail;
    end
  end

  assign mem_addr = AW'(qi) * AW'(QUEUE_DEPTH) + AW'(slot);
  assign mem_we   = exec && q_ok && is_add && !full;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= req_q.entry_tag[SW-1:0];
    end
    if (exec) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        lens[i]  <= '0;
        heads[i] <= '0;
      end
    end else begin
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_pop <= 1'b0;
          if (!q_ok) begin
            res_status <= ST_INVALID;
            res_len    <= '0;
          end else if (is_add) begin
            if (full) begin
              res_status <= ST_FULL;
              res_len    <= len_cur;
            end else begin
              res_status <= ST_ADDED;
              res_len    <= len_cur + 1'b1;
              lens[qi]   <= len_cur + 1'b1;
              if (req_q.urgent) begin
                heads[qi] <= head_dec;
              end
            end
          end else if (len_cur == '0) begin
            res_status <= ST_EMPTY;
            res_len    <= '0;
          end else begin
            res_status <= ST_REMOVED;
            res_len    <= len_cur - 1'b1;
            res_pop    <= 1'b1;
            lens[qi]   <= len_cur - 1'b1;
            heads[qi]  <= head_inc;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_load) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.popped_tag   <= res_pop ? TAG_FIELD_W'(rd_data) : '0;
            rsp.queue_length <= LEN_FIELD_W'(res_len);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "multi_queue_urgent_front_insert_assert.svh"

  `MQUFI_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready while busy")
  `MQUFI_ASSERT_NOW(a_len_bound, exec && q_ok, len_cur <= LW'(QUEUE_DEPTH), "length over depth")
  `MQUFI_ASSERT_NOW(a_invalid_rsp, rsp_valid && rsp.status == ST_INVALID, rsp.popped_tag == '0 && rsp.queue_length == '0, "bad invalid word")
  `MQUFI_ASSERT_NOW(a_write_only_exec, mem_we, exec && !full, "stray memory write")

endmodule

`default_nettype wire
